@@ rtl/w2e_pkg.sv @@
// shared types and constants for the wlan to ethernet frame rewrite unit
// no dependencies; imported by every module of the block
`default_nettype none

package w2e_pkg;

   localparam int unsigned PRISM_HEADER_BYTES = 144;
   localparam int unsigned CMD_QUEUE_DEPTH    = 4;
   localparam int unsigned CMD_PTR_W          = $clog2(CMD_QUEUE_DEPTH);
   localparam int unsigned CMD_CNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam int unsigned HDR_BURST_WORDS    = 14;
   localparam int unsigned HDR_IDX_W          = $clog2(HDR_BURST_WORDS);

   typedef enum logic [1:0] {
      LINK_RAW      = 2'd0,
      LINK_PRISM    = 2'd1,
      LINK_RADIOTAP = 2'd2,
      LINK_PPI      = 2'd3
   } link_type_type;

   // one command from the front to the back: a header burst or a payload word
   typedef struct packed {
      logic        hdr;
      logic [7:0]  data;
      logic        last;
      logic [47:0] dst;
      logic [47:0] src;
      logic [7:0]  type_hi;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/w2e_front.sv @@
// front end: link header skip, 802.11 header parsing, keep/drop decision
// depends on w2e_pkg; pushes commands into w2e_queue
`default_nettype none

module w2e_front
   import w2e_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        first_byte,
   input  wire logic        last_byte,
   input  wire logic [15:0] frame_length,
   output logic             push,
   output cmd_type          cmd
);

   link_type_type link_type_ff;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] hoff_ff, hoff_in;
   logic [15:0] pay_ff, pay_in;
   logic [15:0] fc_ff, fc_in;
   logic [47:0] da_ff, da_in;
   logic [47:0] sa_ff, sa_in;
   logic [7:0]  thi_ff, thi_in;
   logic        qos_ff, qos_in;
   logic        drop_ff, drop_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_type_ff <= LINK_RAW;
         pos_ff  <= '0;
         len_ff  <= '0;
         hoff_ff <= '0;
         pay_ff  <= '0;
         fc_ff   <= '0;
         da_ff   <= '0;
         sa_ff   <= '0;
         thi_ff  <= '0;
         qos_ff  <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            link_type_ff <= link_type_type'(csr_wdata);
         end
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         hoff_ff <= hoff_in;
         pay_ff  <= pay_in;
         fc_ff   <= fc_in;
         da_ff   <= da_in;
         sa_ff   <= sa_in;
         thi_ff  <= thi_in;
         qos_ff  <= qos_in;
         drop_ff <= drop_in;
      end
   end

   always_comb begin
      logic [15:0]        cur_pos;
      logic [15:0]        cur_hoff;
      logic [15:0]        r;
      logic [15:0]        hdr_end;
      logic [15:0]        hoff_hi;
      logic [16:0]        hoff_plus;
      logic [15:0]        fc_full;
      logic signed [17:0] pay_s;
      logic signed [17:0] pay_q;
      logic [15:0]        pay_dec;
      logic [1:0]         addr_sel;
      logic [1:0]         da_sel;
      logic [1:0]         sa_sel;
      logic               is_ext;

      pos_in  = pos_ff;
      len_in  = len_ff;
      hoff_in = hoff_ff;
      pay_in  = pay_ff;
      fc_in   = fc_ff;
      da_in   = da_ff;
      sa_in   = sa_ff;
      thi_in  = thi_ff;
      qos_in  = qos_ff;
      drop_in = drop_ff;
      push    = 1'b0;
      cmd     = '0;

      if (first_byte) begin
         len_in  = frame_length;
         drop_in = 1'b0;
         qos_in  = 1'b0;
         pay_in  = '0;
         fc_in   = '0;
         hoff_in = (link_type_ff == LINK_PRISM) ? 16'(PRISM_HEADER_BYTES) : 16'd0;
      end
      cur_pos  = first_byte ? 16'd0 : pos_ff;
      cur_hoff = hoff_in;
      is_ext   = (link_type_ff == LINK_RADIOTAP) || (link_type_ff == LINK_PPI);
      r        = cur_pos - cur_hoff;
      hdr_end  = qos_in ? 16'd34 : 16'd32;
      hoff_hi  = cur_hoff | {data_byte, 8'h00};
      hoff_plus = {1'b0, hoff_hi} + 17'd10;
      fc_full  = fc_in | {data_byte, 8'h00};
      pay_s    = $signed({2'b00, len_in}) - 18'sd32 - $signed({2'b00, cur_hoff});
      pay_q    = pay_s - 18'sd2;
      pay_dec  = pay_in - 16'd1;
      addr_sel = (r < 16'd10) ? 2'd0 : ((r < 16'd16) ? 2'd1 : 2'd2);
      da_sel   = fc_in[8] ? 2'd2 : 2'd0;
      sa_sel   = fc_in[9] ? 2'd2 : 2'd1;

      cmd.dst     = da_in;
      cmd.src     = sa_in;
      cmd.type_hi = thi_in;
      cmd.data    = data_byte;

      if (accept) begin
         pos_in = (cur_pos != 16'hFFFF) ? cur_pos + 16'd1 : cur_pos;
         if (!drop_in) begin
            if (is_ext && cur_pos <= 16'd3) begin
               // extended link header: length little endian at bytes 2 and 3
               if (cur_pos == 16'd2) begin
                  hoff_in = {8'h00, data_byte};
               end else if (cur_pos == 16'd3) begin
                  hoff_in = hoff_hi;
                  if (hoff_hi < 16'd8) begin
                     drop_in = 1'b1;
                  end else if (link_type_ff == LINK_RADIOTAP &&
                               hoff_plus > {1'b0, len_in}) begin
                     drop_in = 1'b1;
                  end else if (link_type_ff == LINK_PPI &&
                               (len_in < 16'd8 || hoff_hi > len_in)) begin
                     drop_in = 1'b1;
                  end
               end
            end else if (cur_pos >= cur_hoff) begin
               if (r == 16'd0) begin
                  fc_in = {8'h00, data_byte};
               end else if (r == 16'd1) begin
                  fc_in = fc_full;
                  if (pay_s <= 18'sd20 || fc_full[3:2] != 2'd2) begin
                     drop_in = 1'b1;
                  end else if (fc_full[7:4] == 4'd8) begin
                     qos_in = 1'b1;
                     if (pay_q <= 18'sd20 || fc_full[14] || (fc_full[8] && fc_full[9])) begin
                        drop_in = 1'b1;
                     end else begin
                        pay_in = pay_q[15:0];
                     end
                  end else if (fc_full[7:4] != 4'd0 || fc_full[14] ||
                               (fc_full[8] && fc_full[9])) begin
                     drop_in = 1'b1;
                  end else begin
                     pay_in = pay_s[15:0];
                  end
               end else if (r >= 16'd4 && r < 16'd22) begin
                  // addresses arrive msb first
                  if (addr_sel == da_sel) begin
                     da_in = {da_ff[39:0], data_byte};
                  end
                  if (addr_sel == sa_sel) begin
                     sa_in = {sa_ff[39:0], data_byte};
                  end
               end else if (r == hdr_end - 16'd2) begin
                  thi_in = data_byte;
               end else if (r == hdr_end - 16'd1) begin
                  push     = 1'b1;
                  cmd.hdr  = 1'b1;
                  cmd.last = 1'b0;
               end else if (r >= hdr_end && pay_in != 16'd0) begin
                  pay_in   = pay_dec;
                  push     = 1'b1;
                  cmd.hdr  = 1'b0;
                  cmd.last = (pay_dec == 16'd0) || last_byte;
                  if (pay_dec == 16'd0) begin
                     drop_in = 1'b1;
                  end
               end
            end
            if (last_byte) begin
               drop_in = 1'b1;
            end
         end
      end else begin
         pos_in  = pos_ff;
         len_in  = len_ff;
         hoff_in = hoff_ff;
         pay_in  = pay_ff;
         fc_in   = fc_ff;
         da_in   = da_ff;
         sa_in   = sa_ff;
         thi_in  = thi_ff;
         qos_in  = qos_ff;
         drop_in = drop_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/w2e_queue.sv @@
// command queue between front and back, register based
// depends on w2e_pkg
`default_nettype none

module w2e_queue
   import w2e_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      ready,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_cmd
);

   cmd_type                entry_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign ready      = (count_ff != CMD_CNT_W'(CMD_QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/w2e_back.sv @@
// back end: expands header commands into 14 words, forwards payload words
// depends on w2e_pkg; drives the registered output word
`default_nettype none

module w2e_back
   import w2e_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       out_valid,
   input  wire logic  out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   always_comb begin
      logic         load;
      logic [111:0] burst;

      load     = !valid_ff || out_ready;
      burst    = {head_cmd.dst, head_cmd.src, head_cmd.type_hi, head_cmd.data};
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_cmd.hdr) begin
               byte_in = burst[7'd111 - {idx_ff, 3'b000} -: 8];
               last_in = 1'b0;
               if (idx_ff == HDR_IDX_W'(HDR_BURST_WORDS - 1)) begin
                  pop    = 1'b1;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               byte_in = head_cmd.data;
               last_in = head_cmd.last;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

@@ rtl/wlan_to_ethernet_frame_rewrite_unit.sv @@
// top level of the 802.11 capture to ethernet frame rewrite unit
// depends on w2e_pkg, w2e_front, w2e_queue and w2e_back
//
//  channel  direction  signals                       word
//  req      in         req_tvalid/tready/tdata/...   one capture byte with frame marks
//  rsp      out        rsp_tvalid/tready/tdata/tlast one ethernet frame byte
//  csr      in         csr_we/csr_wdata              link type register write
//
// the front takes one byte per cycle while the queue has room, parsing it in that cycle
// a kept frame yields one header command and then one command per payload byte
// the back turns the header command into 14 output words, one per cycle unless rsp stalls;
// the 4-entry queue can fill behind it, and req_tready stays low until the back pops it
// a word passes a queue entry and the back's output register before it shows on rsp
// synchronous reset clears all control state and sets link type to raw 802.11
`default_nettype none

module wlan_to_ethernet_frame_rewrite_unit
   import w2e_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input capture bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] data_byte, [23:8] frame_length
   input  wire logic        req_tuser,   // [0] first_byte
   input  wire logic        req_tlast,   // last_byte
   // output ethernet bytes
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // out_last
   // link type register
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata
);

   logic    q_ready;
   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // a byte is taken whenever the queue has room, even if it ends up dropped
   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   w2e_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .data_byte    (req_tdata[7:0]),
      .first_byte   (req_tuser),
      .last_byte    (req_tlast),
      .frame_length (req_tdata[23:8]),
      .push         (push),
      .cmd          (push_cmd)
   );

   w2e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .ready      (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   w2e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ bench/tb_wlan_to_ethernet_frame_rewrite_unit.sv @@
`timescale 1ns / 100ps
// self-checking bench for the 802.11 capture to ethernet frame rewrite unit
// depends on w2e_pkg and wlan_to_ethernet_frame_rewrite_unit; holds a scoreboard
// class with its own rewrite predictor and plain tasks that drive the streams

module tb_wlan_to_ethernet_frame_rewrite_unit
   import w2e_pkg::*;
();

   // settle time after a phase: covers the header burst and the pipe latency
   localparam int DRAIN_CYCLES = 16;

   // frame control type and subtype codes used to build frames
   localparam logic [1:0] FT_MGMT = 2'd0;
   localparam logic [1:0] FT_CTRL = 2'd1;
   localparam logic [1:0] FT_DATA = 2'd2;
   localparam logic [1:0] FT_EXT  = 2'd3;
   localparam logic [3:0] SUB_DATA = 4'd0;
   localparam logic [3:0] SUB_NULL = 4'd4;
   localparam logic [3:0] SUB_QOS  = 4'd8;

   // content of the free bytes of a frame
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZEROS  = 1;
   localparam int FILL_ONES   = 2;

   // receiver ready patterns
   localparam int READY_ALWAYS = 0;
   localparam int READY_MOSTLY = 1;
   localparam int READY_RARELY = 2;
   localparam int READY_TOGGLE = 3;

   // one frame to send: how it is built and how it is cut short or padded
   typedef struct {
      logic [15:0] fc;
      int          hdr_len;     // radiotap / ppi header length field
      int          pay_len;
      bit          len_forced;  // put len_value on the first byte instead of the true length
      logic [15:0] len_value;
      int          cut_at;      // negative: whole frame
      int          extra;       // trailing bytes past the frame
      bit          no_last;     // frame ends without a last mark (next one restarts it)
      int          fill;
   } frame_plan_type;

   // scoreboard: predicts the ethernet bytes from accepted capture bytes and
   // checks every accepted output byte against the oldest prediction
   class frame_rewrite_scoreboard_type;
      typedef struct {
         logic [7:0] data;
         logic       last;
      } eth_byte_type;

      eth_byte_type  ethernet_bytes_due[$];
      int            errors = 0;
      int            bytes_checked = 0;
      link_type_type link_sel = LINK_RAW;
      logic [15:0]   byte_pos = '0;
      logic [15:0]   length_seen = '0;
      logic [15:0]   hdr_offset = '0;
      logic [15:0]   payload_left = '0;
      logic [15:0]   frame_ctrl = '0;
      logic [47:0]   dst_mac = '0;
      logic [47:0]   src_mac = '0;
      logic [7:0]    ethertype_hi = '0;
      bit            qos_seen = 1'b0;
      bit            discarding = 1'b0;

      function void set_link_type(link_type_type lt);
         link_sel = lt;
      endfunction

      function void push_ethernet_byte(logic [7:0] d, logic l);
         eth_byte_type e;
         e.data = d;
         e.last = l;
         ethernet_bytes_due.push_back(e);
      endfunction

      function void note_capture_byte(logic [7:0] b, logic first_b, logic last_b,
                                      logic [15:0] len);
         logic [15:0] pos;
         logic [15:0] rel;
         logic [15:0] hdr_end;
         logic        to_ds;
         logic        from_ds;
         int          pay;
         int          slot;
         if (first_b) begin
            byte_pos = '0;
            length_seen = len;
            discarding = 1'b0;
            qos_seen = 1'b0;
            payload_left = '0;
            frame_ctrl = '0;
            hdr_offset = (link_sel == LINK_PRISM) ? 16'(PRISM_HEADER_BYTES) : 16'd0;
         end
         pos = byte_pos;
         if (byte_pos != 16'hFFFF) byte_pos++;
         if (discarding) return;

         // radiotap / ppi: header length lives at bytes 2-3, little endian
         if ((link_sel == LINK_RADIOTAP || link_sel == LINK_PPI) && pos <= 16'd3) begin
            if (pos == 16'd2) hdr_offset = {8'h00, b};
            else if (pos == 16'd3) begin
               hdr_offset = hdr_offset | {b, 8'h00};
               if (hdr_offset < 16'd8) discarding = 1'b1;
               else if (link_sel == LINK_RADIOTAP
                        && int'(hdr_offset) + 10 > int'(length_seen)) discarding = 1'b1;
               else if (link_sel == LINK_PPI
                        && (length_seen < 16'd8 || hdr_offset > length_seen))
                  discarding = 1'b1;
            end
            if (last_b) discarding = 1'b1;
            return;
         end
         if (pos < hdr_offset) begin
            if (last_b) discarding = 1'b1;
            return;
         end

         rel = pos - hdr_offset;
         to_ds = frame_ctrl[8];
         from_ds = frame_ctrl[9];
         hdr_end = qos_seen ? 16'd34 : 16'd32;

         if (rel == 16'd0) frame_ctrl = {8'h00, b};
         else if (rel == 16'd1) begin
            frame_ctrl = frame_ctrl | {b, 8'h00};
            pay = int'(length_seen) - 32 - int'(hdr_offset);
            if (pay <= 20 || frame_ctrl[3:2] != FT_DATA) discarding = 1'b1;
            else if (frame_ctrl[7:4] == SUB_QOS) begin
               qos_seen = 1'b1;
               pay -= 2;
               if (pay <= 20) discarding = 1'b1;
            end else if (frame_ctrl[7:4] != SUB_DATA) discarding = 1'b1;
            // protected and wds frames are never rewritten
            if (!discarding && (frame_ctrl[14] || (frame_ctrl[8] && frame_ctrl[9])))
               discarding = 1'b1;
            if (!discarding) payload_left = 16'(pay);
         end else if (rel >= 16'd4 && rel < 16'd22) begin
            slot = (int'(rel) - 4) / 6;
            if (slot == (to_ds ? 2 : 0)) dst_mac = {dst_mac[39:0], b};
            if (slot == (from_ds ? 2 : 1)) src_mac = {src_mac[39:0], b};
         end else if (rel == hdr_end - 16'd2) ethertype_hi = b;
         else if (rel == hdr_end - 16'd1) begin
            for (int i = 0; i < 6; i++) push_ethernet_byte(dst_mac[47 - 8 * i -: 8], 1'b0);
            for (int i = 0; i < 6; i++) push_ethernet_byte(src_mac[47 - 8 * i -: 8], 1'b0);
            push_ethernet_byte(ethertype_hi, 1'b0);
            push_ethernet_byte(b, 1'b0);
         end else if (rel >= hdr_end && payload_left > 16'd0) begin
            payload_left--;
            push_ethernet_byte(b, (payload_left == 16'd0) || last_b);
            if (payload_left == 16'd0) discarding = 1'b1;
         end
         if (last_b) discarding = 1'b1;
      endfunction

      task report_mismatch(string what);
         if (errors < 40) $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_ethernet_byte(logic [7:0] d, logic l);
         eth_byte_type e;
         bytes_checked++;
         if (ethernet_bytes_due.size() == 0) begin
            report_mismatch($sformatf("output byte %0d (%02h last %0b) not expected",
                                      bytes_checked, d, l));
            return;
         end
         e = ethernet_bytes_due.pop_front();
         if (d !== e.data)
            report_mismatch($sformatf("output byte %0d data %02h, expected %02h",
                                      bytes_checked, d, e.data));
         if (l !== e.last)
            report_mismatch($sformatf("output byte %0d last %0b, expected %0b",
                                      bytes_checked, l, e.last));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] data_byte, [23:8] frame_length
   logic        req_tuser = 1'b0; // [0] first_byte
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic        rsp_tlast;        // out_last
   logic        csr_we = 1'b0;
   logic [1:0]  csr_wdata = '0;

   frame_rewrite_scoreboard_type sb;

   // sender burst state, receiver hold-off request
   int burst_left = 0;
   bit sender_gaps = 1'b1;
   int hold_left = 0;
   int rdy_mode = READY_ALWAYS;
   int rdy_left = 0;

   wlan_to_ethernet_frame_rewrite_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(10_000_000);
      $display("Test completed with failures");
      $finish;
   end

   // receiver: check accepted words, then pick tready for the next edge
   // a pending hold-off overrides the pattern and is counted down here
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_ethernet_byte(rsp_tdata, rsp_tlast);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rdy_left == 0) begin
            rdy_mode = $urandom_range(READY_ALWAYS, READY_TOGGLE);
            rdy_left = $urandom_range(16, 128);
         end
         rdy_left--;
         case (rdy_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   function automatic logic [7:0] pick_byte(int fill);
      case (fill)
         FILL_ZEROS: return 8'h00;
         FILL_ONES:  return 8'hFF;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic frame_plan_type data_plan(logic [1:0] ftype, logic [3:0] sub,
                                                logic to_ds, logic from_ds, logic prot,
                                                int pay);
      frame_plan_type p;
      p.fc = {1'b0, prot, 4'b0000, from_ds, to_ds, sub, ftype, 2'b00};
      p.hdr_len = 16;
      p.pay_len = pay;
      p.len_forced = 1'b0;
      p.len_value = '0;
      p.cut_at = -1;
      p.extra = 0;
      p.no_last = 1'b0;
      p.fill = FILL_RANDOM;
      return p;
   endfunction

   // one capture word: opens a new burst after a random gap when the last one ran out,
   // keeps tvalid high within a burst, returns at the accepting edge
   task automatic drive_capture_byte(input logic [7:0] d, input logic first_b,
                                     input logic last_b, input logic [15:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = (sender_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {len, d};
      req_tuser <= first_b;
      req_tlast <= last_b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_capture_byte(d, first_b, last_b, len);
   endtask

   // bytes with no frame start: they continue whatever frame is open
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         drive_capture_byte(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
   endtask

   // build link header + 802.11 header (+ qos) + llc/snap + payload and send it
   task automatic send_frame(input frame_plan_type p);
      logic [7:0]  fb[$];
      logic [15:0] len_field;
      int          hdr_bytes;
      int          planned;
      int          n;
      case (sb.link_sel)
         LINK_PRISM: begin
            for (int i = 0; i < PRISM_HEADER_BYTES; i++) fb.push_back(pick_byte(p.fill));
         end
         LINK_RADIOTAP, LINK_PPI: begin
            // huge header lengths are only announced, a few bytes stand for them
            n = (p.hdr_len < 4 || p.hdr_len > 256) ? 4 : p.hdr_len;
            for (int i = 0; i < n; i++)
               fb.push_back(i == 2 ? 8'(p.hdr_len) :
                             i == 3 ? 8'(p.hdr_len >> 8) : pick_byte(p.fill));
         end
         default: ;
      endcase
      hdr_bytes = fb.size();
      fb.push_back(p.fc[7:0]);
      fb.push_back(p.fc[15:8]);
      // duration, three addresses, sequence control
      for (int i = 0; i < 22; i++) fb.push_back(pick_byte(p.fill));
      if (p.fc[7:4] == SUB_QOS) begin
         fb.push_back(pick_byte(p.fill));
         fb.push_back(pick_byte(p.fill));
      end
      fb.push_back(8'hAA);
      fb.push_back(8'hAA);
      fb.push_back(8'h03);
      fb.push_back(8'h00);
      fb.push_back(8'h00);
      fb.push_back(8'h00);
      fb.push_back(pick_byte(p.fill));
      fb.push_back(pick_byte(p.fill));
      for (int i = 0; i < p.pay_len; i++) fb.push_back(pick_byte(p.fill));

      planned = fb.size();
      if ((sb.link_sel == LINK_RADIOTAP || sb.link_sel == LINK_PPI) && p.hdr_len > 256)
         planned = planned - hdr_bytes + p.hdr_len;
      len_field = p.len_forced ? p.len_value :
                  (planned > 65535 ? 16'hFFFF : 16'(planned));
      if (p.cut_at > 0)
         while (fb.size() > p.cut_at) void'(fb.pop_back());
      for (int i = 0; i < p.extra; i++) fb.push_back(8'($urandom));
      for (int i = 0; i < fb.size(); i++)
         drive_capture_byte(fb[i], i == 0, (i == fb.size() - 1) && !p.no_last,
                            i == 0 ? len_field : 16'($urandom));
   endtask

   task automatic write_link_type(input link_type_type lt);
      csr_we <= 1'b1;
      csr_wdata <= lt;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_link_type(lt);
   endtask

   // stop sending, wait for every predicted byte, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.ethernet_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      frame_plan_type p;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // raw 802.11: kept frames, address selection, dropped kinds of frame
      write_link_type(LINK_RAW);
      send_noise(2);                                  // bytes before any frame start
      // long receiver hold-off under a gapless sender: the input must stall
      sender_gaps = 1'b0;
      hold_left = 80;
      p = data_plan(FT_DATA, SUB_DATA, 1'b1, 1'b0, 1'b0, 21);
      p.extra = 2;                                    // bytes past the counted payload
      send_frame(p);                                  // shortest kept payload
      sender_gaps = 1'b1;
      p = data_plan(FT_DATA, SUB_QOS, 1'b0, 1'b1, 1'b0, 21);
      p.cut_at = 40;                                  // ends inside the payload
      send_frame(p);
      p = data_plan(FT_DATA, SUB_DATA, 1'b0, 1'b0, 1'b1, 30);  // protected
      p.cut_at = 6;
      p.no_last = 1'b1;                               // next frame start cuts this one off
      send_frame(p);
      p = data_plan(FT_DATA, SUB_DATA, 1'b1, 1'b1, 1'b0, 30);  // wds
      p.cut_at = 6;
      p.fill = FILL_ONES;
      send_frame(p);
      p = data_plan(FT_DATA, SUB_DATA, 1'b0, 1'b0, 1'b0, 20);  // payload too short
      p.cut_at = 4;
      send_frame(p);
      p = data_plan(FT_DATA, SUB_DATA, 1'b0, 1'b0, 1'b0, 30);
      p.len_forced = 1'b1;
      p.len_value = 16'h0000;
      p.cut_at = 4;
      send_frame(p);
      p = data_plan(FT_MGMT, SUB_DATA, 1'b0, 1'b0, 1'b0, 30);
      p.cut_at = 4;
      send_frame(p);
      p = data_plan(FT_CTRL, SUB_DATA, 1'b0, 1'b0, 1'b0, 30);
      p.cut_at = 4;
      send_frame(p);
      p = data_plan(FT_EXT, SUB_QOS, 1'b0, 1'b0, 1'b0, 30);
      p.cut_at = 4;
      send_frame(p);
      p = data_plan(FT_DATA, SUB_NULL, 1'b0, 1'b0, 1'b0, 30);
      p.cut_at = 4;
      send_frame(p);
      drain();

      // prism header of fixed size, frame ends inside it
      write_link_type(LINK_PRISM);
      p = data_plan(FT_DATA, SUB_DATA, 1'b0, 1'b1, 1'b0, 24);
      p.cut_at = 10;
      p.fill = FILL_ZEROS;
      send_frame(p);
      drain();

      // radiotap: header too small, header longer than the frame allows
      write_link_type(LINK_RADIOTAP);
      p = data_plan(FT_DATA, SUB_QOS, 1'b1, 1'b0, 1'b0, 22);
      p.cut_at = 5;
      p.hdr_len = 7;
      send_frame(p);
      p.hdr_len = 65535;
      send_frame(p);
      drain();

      // ppi: header length above the frame length
      write_link_type(LINK_PPI);
      p = data_plan(FT_DATA, SUB_DATA, 1'b0, 1'b1, 1'b0, 21);
      p.hdr_len = 40;
      p.len_forced = 1'b1;
      p.len_value = 16'd30;
      p.cut_at = 5;
      send_frame(p);
      drain();

      if (sb.ethernet_bytes_due.size() != 0)
         sb.report_mismatch($sformatf("%0d expected bytes never came out",
                                      sb.ethernet_bytes_due.size()));
      if (sb.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/w2e_pkg.sv
rtl/w2e_front.sv
rtl/w2e_queue.sv
rtl/w2e_back.sv
rtl/wlan_to_ethernet_frame_rewrite_unit.sv
bench/tb_wlan_to_ethernet_frame_rewrite_unit.sv
